// ===== hw/rtl/mf3_pkg.sv =====
// Shared constants, types and register codes of the 3x3 median filter.
package mf3_pkg;

   // Frame size limits of the line buffers and row counter.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int DIM_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WEFF_W = (DIM_W > $clog2(MAX_WIDTH + 1)) ? DIM_W : $clog2(MAX_WIDTH + 1);
   localparam int HEFF_W = (DIM_W > $clog2(MAX_HEIGHT + 3)) ? DIM_W : $clog2(MAX_HEIGHT + 3);
   localparam int LB_W   = 2 * PIX_W;
   localparam int CLR_W  = $clog2(MAX_WIDTH + 1);

   // Configuration register map.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(512);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(512);

   // Input operation codes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Queue between the classifier and the filter datapath.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [PIX_W-1:0] pix_type;

   // Nine window values, element r*3+c is row r, column c.
   typedef logic [8:0][PIX_W-1:0] window_type;

   // One classified item on its way to the datapath.
   typedef struct packed {
      pix_type            pixel;
      logic [COL_W-1:0]   column;
      logic               row_ge1;
      logic               row_ge2;
      logic               emit_edge;
      logic               width_one;
      logic               emit_inner;
      logic               column_one;
      logic               last;
   } item_type;

endpackage

// ===== hw/rtl/mf3_if.sv =====
// Handshake channel interfaces for pixels, results and register writes.
interface mf3_req_if;
   import mf3_pkg::*;
   logic          valid;
   logic          ready;
   logic          operation;
   logic [PIX_W-1:0] pixel_value;
   modport source (output valid, output operation, output pixel_value, input ready);
   modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

interface mf3_rsp_if;
   import mf3_pkg::*;
   logic          valid;
   logic          ready;
   logic [PIX_W-1:0] median_value;
   logic          frame_last;
   modport source (output valid, output median_value, output frame_last, input ready);
   modport sink   (input valid, input median_value, input frame_last, output ready);
endinterface

interface mf3_csr_if;
   import mf3_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mf3_front.sv =====
// Front end: configuration registers, stream position tracking and item classification.
module mf3_front (
   input  logic              clock,
   input  logic              reset,
   mf3_req_if.sink           req_chan,
   mf3_csr_if.sink           csr_chan,
   input  logic              clear_busy,
   input  logic              queue_full,
   output logic              push,
   output mf3_pkg::item_type push_item
);
   import mf3_pkg::*;

   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [HEFF_W-1:0] row_ff, row_in;

   logic [WEFF_W-1:0] width_ext, w_eff, col_next_ext;
   logic [HEFF_W-1:0] height_ext, h_eff, h_plus1, row_step, cur_row;
   logic [COL_W-1:0]  cur_col;
   logic              col_wrap, restart, in_image, row_ge1, row_ge2;
   logic              emit_edge, emit_inner, last;

   // Register writes are always taken in the cycle they are offered.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_chan.data;
            REG_IMAGE_HEIGHT: height_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Effective frame size: zero counts as one, large values saturate.
   assign width_ext  = WEFF_W'(width_ff);
   assign height_ext = HEFF_W'(height_ff);
   assign w_eff = (width_ff == '0) ? WEFF_W'(1) :
                  (width_ext > WEFF_W'(MAX_WIDTH)) ? WEFF_W'(MAX_WIDTH) : width_ext;
   assign h_eff = (height_ff == '0) ? HEFF_W'(1) :
                  (height_ext > HEFF_W'(MAX_HEIGHT)) ? HEFF_W'(MAX_HEIGHT) : height_ext;
   assign h_plus1 = h_eff + HEFF_W'(1);

   // Position of this item, after any wrap forced by a size change.
   assign col_wrap = WEFF_W'(col_ff) >= w_eff;
   assign row_step = col_wrap ? row_ff + HEFF_W'(1) : row_ff;
   assign restart  = row_step > h_plus1;
   assign cur_row  = restart ? '0 : row_step;
   assign cur_col  = (restart || col_wrap) ? '0 : col_ff;

   // Classification of the item.
   assign row_ge1    = cur_row != '0;
   assign row_ge2    = cur_row >= HEFF_W'(2);
   assign in_image   = cur_row < h_eff;
   assign emit_edge  = (cur_col == '0) && row_ge2;
   assign emit_inner = (cur_col != '0) && row_ge1;
   assign last       = emit_edge && (cur_row == h_plus1);

   always_comb begin
      push_item            = '0;
      push_item.pixel      = (req_chan.operation == OP_DRAIN || !in_image) ?
                             '0 : req_chan.pixel_value;
      push_item.column     = cur_col;
      push_item.row_ge1    = row_ge1;
      push_item.row_ge2    = row_ge2;
      push_item.emit_edge  = emit_edge;
      push_item.width_one  = w_eff == WEFF_W'(1);
      push_item.emit_inner = emit_inner;
      push_item.column_one = cur_col == COL_W'(1);
      push_item.last       = last;
   end

   // Position of the next item.
   assign col_next_ext = WEFF_W'(cur_col) + WEFF_W'(1);

   always_comb begin
      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_next_ext >= w_eff) begin
         col_in = '0;
         row_in = cur_row + HEFF_W'(1);
      end else begin
         col_in = col_next_ext[COL_W-1:0];
         row_in = cur_row;
      end
   end

   assign req_chan.ready = !queue_full && !clear_busy;
   assign push = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hw/rtl/mf3_queue.sv =====
// Short item queue that decouples the front end from the filter datapath.
module mf3_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mf3_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mf3_pkg::item_type head
);
   import mf3_pkg::*;

   item_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;

   assign full       = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - FIFO_CNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/mf3_median.sv =====
// Three-stage median-of-nine network; the last stage is the result register.
module mf3_median (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  mf3_pkg::window_type in_window,
   input  logic                in_last,
   output logic                out_valid,
   output mf3_pkg::pix_type    out_median,
   output logic                out_last
);
   import mf3_pkg::*;

   logic [2:0][PIX_W-1:0] s1_lo_ff, s1_md_ff, s1_hi_ff;
   logic [2:0][PIX_W-1:0] s1_lo_in, s1_md_in, s1_hi_in;
   logic                  s1_valid_ff, s1_last_ff;
   pix_type               s2_lo_ff, s2_md_ff, s2_hi_ff;
   logic                  s2_valid_ff, s2_last_ff;
   pix_type               med_ff;
   logic                  valid_ff, last_ff;

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a > b) ? b : a;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // First stage: sort each window row.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s1_lo_in[r] = min2(min2(in_window[r*3], in_window[r*3+1]), in_window[r*3+2]);
         s1_hi_in[r] = max2(max2(in_window[r*3], in_window[r*3+1]), in_window[r*3+2]);
         s1_md_in[r] = med3(in_window[r*3], in_window[r*3+1], in_window[r*3+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_lo_ff   <= s1_lo_in;
         s1_md_ff   <= s1_md_in;
         s1_hi_ff   <= s1_hi_in;
         s1_last_ff <= in_last;
         s2_lo_ff   <= max2(max2(s1_lo_ff[0], s1_lo_ff[1]), s1_lo_ff[2]);
         s2_md_ff   <= med3(s1_md_ff[0], s1_md_ff[1], s1_md_ff[2]);
         s2_hi_ff   <= min2(min2(s1_hi_ff[0], s1_hi_ff[1]), s1_hi_ff[2]);
         s2_last_ff <= s1_last_ff;
         med_ff     <= med3(s2_lo_ff, s2_md_ff, s2_hi_ff);
         last_ff    <= s2_last_ff;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         valid_ff    <= s2_valid_ff;
      end
   end

   assign out_valid  = valid_ff;
   assign out_median = med_ff;
   assign out_last   = last_ff;

endmodule

// ===== hw/rtl/mf3_back.sv =====
// Back end: line buffer memory, window registers and the median pipeline.
module mf3_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  mf3_pkg::item_type head,
   output logic              pop,
   output logic              clear_busy,
   mf3_rsp_if.source         rsp_chan
);
   import mf3_pkg::*;

   // Each entry holds {two rows above, row above} for one column.
   logic [LB_W-1:0]  lb_mem [MAX_WIDTH];
   logic [LB_W-1:0]  mem_rd_ff;
   logic [CLR_W-1:0] clr_cnt_ff;

   logic             b2_valid_ff;
   item_type         b2_item_ff;
   window_type       win_ff;

   logic             wr_valid_ff;
   logic [COL_W-1:0] wr_addr_ff;
   logic [LB_W-1:0]  wr_data_ff;

   logic             advance, item_write, mem_we;
   logic [COL_W-1:0] mem_wa;
   logic [LB_W-1:0]  mem_wd, rd_word;
   pix_type          rd_above, rd_two, top, mid;
   logic             zero_left, med_in_valid;
   window_type       cur;
   logic             med_valid, med_last;
   pix_type          med_value;

   // Whole datapath moves when the result register is free or being taken.
   assign advance = !med_valid || rsp_chan.ready;
   assign pop     = advance && head_valid && !clear_busy;

   // Clearing sweep of the line buffer after reset.
   assign clear_busy = clr_cnt_ff < CLR_W'(MAX_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clear_busy) begin
         clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
      end
   end

   // Line buffer read as the item leaves the queue.
   always_ff @(posedge clock) begin
      if (pop) begin
         mem_rd_ff <= lb_mem[head.column];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lb_mem[mem_wa] <= mem_wd;
      end
   end

   // Item stage that updates the buffer and window.
   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (advance) begin
         b2_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b2_item_ff <= head;
      end
   end

   // Bypass of the previous write when the read came too early to see it.
   assign rd_word  = (wr_valid_ff && wr_addr_ff == b2_item_ff.column) ? wr_data_ff : mem_rd_ff;
   assign rd_above = rd_word[PIX_W-1:0];
   assign rd_two   = rd_word[LB_W-1:PIX_W];
   assign top      = b2_item_ff.row_ge2 ? rd_two : '0;
   assign mid      = b2_item_ff.row_ge1 ? rd_above : '0;

   assign item_write = b2_valid_ff && advance;
   assign mem_we     = clear_busy || item_write;
   assign mem_wa     = clear_busy ? clr_cnt_ff[COL_W-1:0] : b2_item_ff.column;
   assign mem_wd     = clear_busy ? '0 : {rd_above, b2_item_ff.pixel};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (item_write) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_write) begin
         wr_addr_ff <= b2_item_ff.column;
         wr_data_ff <= mem_wd;
      end
   end

   // Window shifts left by one column per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (item_write) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= top;
         win_ff[5] <= mid;
         win_ff[8] <= b2_item_ff.pixel;
      end
   end

   // Window for the median, with padding at the left and right image edges.
   assign zero_left = (b2_item_ff.emit_edge && b2_item_ff.width_one) ||
                      (b2_item_ff.emit_inner && b2_item_ff.column_one);

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cur[r*3]   = zero_left ? '0 : win_ff[r*3+1];
         cur[r*3+1] = win_ff[r*3+2];
      end
      cur[2] = b2_item_ff.emit_edge ? '0 : top;
      cur[5] = b2_item_ff.emit_edge ? '0 : mid;
      cur[8] = b2_item_ff.emit_edge ? '0 : b2_item_ff.pixel;
   end

   assign med_in_valid = b2_valid_ff && (b2_item_ff.emit_edge || b2_item_ff.emit_inner);

   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (med_in_valid),
      .in_window  (cur),
      .in_last    (b2_item_ff.last),
      .out_valid  (med_valid),
      .out_median (med_value),
      .out_last   (med_last)
   );

   assign rsp_chan.valid        = med_valid;
   assign rsp_chan.median_value = med_value;
   assign rsp_chan.frame_last   = med_last;

`ifndef SYNTHESIS
   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> (!head_valid && !b2_valid_ff))
      else $error("item in flight during line buffer clear");

   a_single_emit: assert property (@(posedge clock) disable iff (reset)
      b2_valid_ff |-> !(b2_item_ff.emit_edge && b2_item_ff.emit_inner))
      else $error("item classified as both edge and inner result");

   a_last_on_edge: assert property (@(posedge clock) disable iff (reset)
      (b2_valid_ff && b2_item_ff.last) |-> b2_item_ff.emit_edge)
      else $error("frame end flagged on an item without an edge result");

   a_result_after_write: assert property (@(posedge clock) disable iff (reset)
      (advance && !med_valid && !clear_busy && $past(!b2_valid_ff && !advance)) |->
         !$past(med_in_valid))
      else $error("result produced without an item");
`endif

endmodule

// ===== hw/rtl/median_filter_3x3_core.sv =====
// Each pixel beat reads and writes the line buffer once on its way to the median stages.
// Throughput: one pixel beat per clock while the datapath is not stalled.
// A full result register stalls the datapath and the queue; req ready falls once it fills.
// Reset: synchronous; width and height return to 512 and the line buffer is swept to
// zero, during which req ready stays low and register writes are taken.
module median_filter_3x3_core (
   input  logic     clock,
   input  logic     reset,
   mf3_req_if.sink  req_chan,
   mf3_rsp_if.source rsp_chan,
   mf3_csr_if.sink  csr_chan
);
   import mf3_pkg::*;

   logic     push, queue_full, pop, head_valid, clear_busy;
   item_type push_item, head;

   mf3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .clear_busy (clear_busy),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   mf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   mf3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== tb/median_filter_3x3_core_tb.sv =====
// Self-checking testbench of the streaming 3x3 median filter core.
module median_filter_3x3_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mf3_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 950;
   localparam int SETTLE_CYCLES = 8;

   // One expected result beat.
   typedef struct packed {
      pix_type median;
      logic    frame_last;
   } median_beat_type;

   logic clock;
   logic reset;

   mf3_req_if req_bus ();
   mf3_rsp_if rsp_bus ();
   mf3_csr_if csr_bus ();

   median_filter_3x3_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow of the filter: register copies, line buffers, window and stream position.
   logic [DIM_W-1:0] cols_cfg;
   logic [DIM_W-1:0] rows_cfg;
   pix_type          line_prev  [MAX_WIDTH];
   pix_type          line_prev2 [MAX_WIDTH];
   window_type       window_now;
   int               pos_col;
   int               pos_row;

   median_beat_type expected_medians[$];
   median_beat_type oldest_median;
   int              errors;
   int              cycle_count;
   int              items_sent;
   bit              no_gaps;

   // Clock generation.
   initial begin
      clock = 1'b0;
   end
   always #10 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("median_filter_3x3_core_tb NOT OK");
         $finish;
      end
   end

   // Result side back-pressure, with a steady stretch when gaps are off.
   always @(negedge clock) begin
      rsp_bus.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 15);
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_medians.size() == 0) begin
            $display("%0t: unexpected result beat, median %0d last %0b", $time,
                     rsp_bus.median_value, rsp_bus.frame_last);
            errors++;
         end else begin
            oldest_median = expected_medians.pop_front();
            if (rsp_bus.median_value !== oldest_median.median) begin
               $display("%0t: median expected %0d actual %0d", $time,
                        oldest_median.median, rsp_bus.median_value);
               errors++;
            end
            if (rsp_bus.frame_last !== oldest_median.frame_last) begin
               $display("%0t: frame_last expected %0b actual %0b", $time,
                        oldest_median.frame_last, rsp_bus.frame_last);
               errors++;
            end
         end
      end
   end

   // A zero size counts as one, anything above the buffer size saturates.
   function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
      if (v == 0) begin
         return 1;
      end
      if (int'(v) > maxv) begin
         return maxv;
      end
      return int'(v);
   endfunction

   // Middle value of nine: insertion sort, then the fifth smallest.
   function automatic pix_type median_of_window(window_type w);
      pix_type s[9];
      pix_type key;
      int      i;
      int      j;
      for (i = 0; i < 9; i++) begin
         s[i] = w[i];
      end
      for (i = 1; i < 9; i++) begin
         key = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > key) begin
            s[j + 1] = s[j];
            j--;
         end
         s[j + 1] = key;
      end
      return s[4];
   endfunction

   // Advance the shadow filter by one accepted beat and queue any result it causes.
   task automatic predict_filter(input logic op, input pix_type pix);
      int              w;
      int              h;
      int              i;
      int              j;
      int              r;
      pix_type         v;
      pix_type         top;
      pix_type         mid;
      window_type      cur;
      bit              emit;
      bit              last;
      median_beat_type beat;
      w = clamp_dim(cols_cfg, MAX_WIDTH);
      h = clamp_dim(rows_cfg, MAX_HEIGHT);
      emit = 1'b0;
      last = 1'b0;
      cur = '0;
      // The position alone decides where this beat lands.
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row > h + 1) begin
         pos_row = 0;
         pos_col = 0;
      end
      i = pos_row;
      j = pos_col;
      v = (op == OP_DRAIN || i >= h) ? '0 : pix;

      // Row start: the previous row's last centre with right padding.
      if (j == 0 && i >= 2) begin
         for (r = 0; r < 3; r++) begin
            cur[r*3]     = (w == 1) ? '0 : window_now[r*3+1];
            cur[r*3 + 1] = window_now[r*3+2];
            cur[r*3 + 2] = '0;
         end
         emit = 1'b1;
         last = (i == h + 1);
      end

      // Line buffers and window shift.
      top = (i >= 2) ? line_prev2[j] : '0;
      mid = (i >= 1) ? line_prev[j] : '0;
      line_prev2[j] = line_prev[j];
      line_prev[j] = v;
      for (r = 0; r < 3; r++) begin
         window_now[r*3]     = window_now[r*3+1];
         window_now[r*3 + 1] = window_now[r*3+2];
      end
      window_now[2] = top;
      window_now[5] = mid;
      window_now[8] = v;

      // Interior centre one row up and one column left, left padding at column one.
      if (j >= 1 && i >= 1) begin
         cur = window_now;
         if (j == 1) begin
            cur[0] = '0;
            cur[3] = '0;
            cur[6] = '0;
         end
         emit = 1'b1;
         last = 1'b0;
      end

      if (last) begin
         pos_row = 0;
         pos_col = 0;
      end else begin
         pos_col = j + 1;
         if (pos_col >= w) begin
            pos_col = 0;
            pos_row = i + 1;
         end
      end

      if (emit) begin
         beat.median = median_of_window(cur);
         beat.frame_last = last;
         expected_medians.push_back(beat);
      end
   endtask

   // Grey level biased toward the two extremes.
   function automatic pix_type rand_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return pix_type'($urandom_range(255));
      endcase
   endfunction

   // Send one request beat, with an occasional gap before it.
   task automatic send_item(input logic op, input pix_type pix);
      @(negedge clock);
      if (!no_gaps && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.pixel_value <= pix;
      do @(posedge clock); while (!req_bus.ready);
      predict_filter(op, pix);
      items_sent++;
   endtask

   // Stop sending and wait until every expected result has come and the pipe is empty.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_medians.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write beat; the shadow copy follows on acceptance.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == REG_IMAGE_WIDTH) begin
         cols_cfg = data;
      end else if (idx == REG_IMAGE_HEIGHT) begin
         rows_cfg = data;
      end
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      settle();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   // Pad with drain beats until the stream is back at the start of a frame.
   task automatic finish_frame();
      while (pos_row != 0 || pos_col != 0) begin
         send_item(OP_DRAIN, rand_pixel());
      end
   endtask

   // One frame at the current size: clean, with flipped operations, or cut short.
   task automatic send_frame(input int style);
      int w;
      int h;
      int n;
      int stop_at;
      int k;
      logic op;
      w = clamp_dim(cols_cfg, MAX_WIDTH);
      h = clamp_dim(rows_cfg, MAX_HEIGHT);
      n = w * h + w + 1;
      stop_at = (style == 2) ? $urandom_range(1, n - 1 > 1 ? n - 1 : 1) : n;
      for (k = 0; k < stop_at; k++) begin
         op = (k < w * h) ? OP_PIXEL : OP_DRAIN;
         if (style == 1 && $urandom_range(9) == 0) begin
            op = ~op;
         end
         send_item(op, rand_pixel());
      end
   endtask

   // Default 512 x 512 size, then a size change in the middle of a row.
   task automatic test_reset_size();
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_DRAIN, 8'd0);
      send_item(OP_PIXEL, 8'd128);
      set_size(11'd2, 11'd0);
      finish_frame();
   endtask

   // A one-pixel frame, and a 3 x 3 frame with a drain inside and a pixel in the padding.
   task automatic test_tiny_frames();
      set_size(11'd0, 11'd0);
      send_item(OP_PIXEL, 8'd200);
      send_item(OP_DRAIN, 8'd17);
      send_item(OP_DRAIN, 8'd255);
      set_size(11'd3, 11'd3);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_PIXEL, 8'd0);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_DRAIN, 8'd255);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_PIXEL, 8'd0);
      send_item(OP_PIXEL, 8'd128);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_PIXEL, 8'd77);
      send_item(OP_DRAIN, 8'd0);
      send_item(OP_DRAIN, 8'd0);
      send_item(OP_DRAIN, 8'd0);
   endtask

   // Sizes above the maximum and at the maximum, each left in the middle of a row.
   task automatic test_size_limits();
      set_size(11'd2047, 11'd2047);
      repeat (4) send_item(OP_PIXEL, rand_pixel());
      set_size(11'd1024, 11'd1024);
      send_item(OP_PIXEL, rand_pixel());
   endtask

   // Random small frames, mostly clean, some noisy and some cut short.
   task automatic test_random_frames();
      int first_item;
      int frame_no;
      int style;
      first_item = items_sent;
      frame_no = 0;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         set_size(($urandom_range(9) == 0) ? DIM_W'($urandom_range(9, 40)) :
                  DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 6)));
         if ($urandom_range(1) == 1) begin
            finish_frame();
         end
         no_gaps = (frame_no >= 6 && frame_no < 14);
         style = $urandom_range(99);
         send_frame(style < 75 ? 0 : (style < 85 ? 1 : 2));
         frame_no++;
      end
      no_gaps = 1'b0;
      finish_frame();
   endtask

   // Stimulus sequence.
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_PIXEL;
      req_bus.pixel_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_IMAGE_WIDTH;
      csr_bus.data = '0;
      cols_cfg = WIDTH_RESET;
      rows_cfg = HEIGHT_RESET;
      window_now = '0;
      pos_col = 0;
      pos_row = 0;
      for (int a = 0; a < MAX_WIDTH; a++) begin
         line_prev[a] = '0;
         line_prev2[a] = '0;
      end
      errors = 0;
      cycle_count = 0;
      items_sent = 0;
      no_gaps = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_tiny_frames();
      test_size_limits();
      test_random_frames();

      settle();
      if (errors == 0) begin
         $display("median_filter_3x3_core_tb OK");
      end else begin
         $display("median_filter_3x3_core_tb NOT OK");
      end
      $finish;
   end

endmodule
